/* src/variable_partition_allocator_unit_assert.svh */
// Assertion macros used by the checker file.
`ifndef VARIABLE_PARTITION_ALLOCATOR_UNIT_ASSERT_SVH
`define VARIABLE_PARTITION_ALLOCATOR_UNIT_ASSERT_SVH
`define VPA_ASSERT_IMPL(lbl, a, c, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) else $error(msg);
`define VPA_ASSERT_NEXT(lbl, a, c, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) else $error(msg);
`endif

/* src/vpa_pkg.sv */
// ----------------------------------------------------------------------------
// vpa_pkg
// Types, codes and defaults of the variable partition allocator.
// ----------------------------------------------------------------------------
package vpa_pkg;
	localparam int unsigned POOL_SIZE_DEF    = 16384;
	localparam int unsigned MAX_SEGMENTS_DEF = 16;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_NO_SPACE  = 3'd1,
		ST_NOT_FOUND = 3'd2,
		ST_FULL      = 3'd3,
		ST_ZERO      = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		FIT_FIRST = 2'd0,
		FIT_NEXT  = 2'd1,
		FIT_BEST  = 2'd2,
		FIT_WORST = 2'd3
	} fit_t;

	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	typedef struct packed {
		logic        kind;
		logic [1:0]  fit_policy;
		logic [14:0] alloc_size;
		logic [15:0] free_id;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [13:0] seg_start;
		logic [14:0] seg_size;
		logic [15:0] assigned_id;
	} rsp_t;
endpackage

/* src/vpa_cell.sv */
// ----------------------------------------------------------------------------
// vpa_cell
// One table entry: a start and a size with a valid bit, able to load,
// take its neighbour's contents or hold.
// ----------------------------------------------------------------------------
module vpa_cell #(
	parameter int unsigned AW = 14,
	parameter int unsigned SW = 15,
	parameter int unsigned IW = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rst_valid,
	input  logic [AW-1:0] rst_start,
	input  logic [SW-1:0] rst_size,
	input  logic          ld,
	input  logic          ld_valid,
	input  logic [AW-1:0] ld_start,
	input  logic [SW-1:0] ld_size,
	input  logic [IW-1:0] ld_id,
	output logic          valid_q,
	output logic [AW-1:0] start_q,
	output logic [SW-1:0] size_q,
	output logic [IW-1:0] id_q
);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= rst_valid;
			start_q <= rst_start;
			size_q  <= rst_size;
			id_q    <= '0;
		end else if (ld) begin
			valid_q <= ld_valid;
			start_q <= ld_start;
			size_q  <= ld_size;
			id_q    <= ld_id;
		end
	end
endmodule

/* src/variable_partition_allocator_unit.sv */
// ----------------------------------------------------------------------------
// variable_partition_allocator_unit
// Pool allocator with first, next, best and worst fit and merging release.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. The free and used
// tables are rows of cells; a sequencer walks one entry per cycle to scan
// them, and where a gap must open or close, the free row shifts one place
// per cycle. The result appears for one cycle with done high and cannot be
// held off by the receiver.
module variable_partition_allocator_unit #(
	parameter int unsigned POOL_SIZE    = vpa_pkg::POOL_SIZE_DEF,
	parameter int unsigned MAX_SEGMENTS = vpa_pkg::MAX_SEGMENTS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  vpa_pkg::req_t req,
	output logic          busy,
	output logic          done,
	output vpa_pkg::rsp_t rsp
);
	localparam int unsigned AW = $clog2(POOL_SIZE);
	localparam int unsigned SW = AW + 1;
	localparam int unsigned N  = MAX_SEGMENTS;
	localparam int unsigned XW = $clog2(N);
	localparam int unsigned CW = XW + 1;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_SCAN  = 6'b000010,
		S_PICK  = 6'b000100,
		S_SHIFT = 6'b001000,
		S_APPLY = 6'b010000,
		S_DONE  = 6'b100000
	} state_t;

	state_t state_q;
	vpa_pkg::req_t req_q;
	logic [CW-1:0] idx_q, cnt_q, pos_q;
	logic [SW-1:0] fcount_q;
	logic [AW:0]   nfp_q;
	logic [15:0]   nid_q;
	logic          hit_q, hit2_q, slot_ok_q, wrapped_q;
	logic [XW-1:0] hit_idx_q, slot_q, first_q;
	logic [SW-1:0] best_size_q;
	logic [AW-1:0] u_start_q;
	logic [SW-1:0] u_size_q;
	logic          left_q, right_q;
	vpa_pkg::rsp_t rsp_q;
	logic          done_q;

	logic [N-1:0]  f_valid, u_valid, f_ld, u_ld, f_lv, u_lv;
	logic [AW-1:0] f_start [N], u_start [N], f_ls [N], u_ls [N];
	logic [SW-1:0] f_size [N], u_size [N], f_lz [N], u_lz [N];
	logic [15:0]   f_id [N], u_id [N], u_lid [N];

	function automatic vpa_pkg::rsp_t mk_rsp(logic [2:0] st, logic [13:0] s,
		logic [14:0] z, logic [15:0] id);
		vpa_pkg::rsp_t r;
		r.status      = st;
		r.seg_start   = s;
		r.seg_size    = z;
		r.assigned_id = id;
		return r;
	endfunction

	for (genvar g = 0; g < N; g++) begin : g_cells
		vpa_cell #(.AW(AW), .SW(SW), .IW(16)) u_free (
			.clk, .arst_n,
			.rst_valid(g == 0), .rst_start('0),
			.rst_size((g == 0) ? SW'(POOL_SIZE) : '0),
			.ld(f_ld[g]), .ld_valid(f_lv[g]), .ld_start(f_ls[g]), .ld_size(f_lz[g]),
			.ld_id('0),
			.valid_q(f_valid[g]), .start_q(f_start[g]), .size_q(f_size[g]), .id_q(f_id[g])
		);
		vpa_cell #(.AW(AW), .SW(SW), .IW(16)) u_used (
			.clk, .arst_n,
			.rst_valid(1'b0), .rst_start('0), .rst_size('0),
			.ld(u_ld[g]), .ld_valid(u_lv[g]), .ld_start(u_ls[g]), .ld_size(u_lz[g]),
			.ld_id(u_lid[g]),
			.valid_q(u_valid[g]), .start_q(u_start[g]), .size_q(u_size[g]), .id_q(u_id[g])
		);
	end

	logic [XW-1:0] ix, im, pp, pm;
	logic [SW-1:0] req_sz;
	logic [AW-1:0] fs_ix;
	logic [SW-1:0] fz_ix;
	logic [AW:0]   fend_ix, pend, nend;
	logic          ins, rem;
	logic [AW:0]   new_start;

	assign ix      = idx_q[XW-1:0];
	assign im      = ix - XW'(1);
	assign pp      = pos_q[XW-1:0];
	assign pm      = pp - XW'(1);
	assign req_sz  = SW'(req_q.alloc_size);
	assign fs_ix   = f_start[ix];
	assign fz_ix   = f_size[ix];
	assign fend_ix = (AW+1)'(fs_ix) + (AW+1)'(fz_ix);
	assign pend    = (AW+1)'(f_start[im]) + (AW+1)'(f_size[im]);
	assign nend    = (AW+1)'(u_start_q) + (AW+1)'(u_size_q);
	assign new_start = (AW+1)'(f_start[hit_idx_q]) + (AW+1)'(req_sz);
	// Insert on a lone release, remove on an emptied segment or a double merge.
	assign ins = (req_q.kind == vpa_pkg::KIND_FREE) && !left_q && !right_q;
	assign rem = (req_q.kind == vpa_pkg::KIND_FREE) ? (left_q && right_q)
		: (f_size[hit_idx_q] == req_sz);

	always_comb begin
		for (int i = 0; i < N; i++) begin
			f_ld[i] = 1'b0; f_lv[i] = f_valid[i]; f_ls[i] = f_start[i]; f_lz[i] = f_size[i];
			u_ld[i] = 1'b0; u_lv[i] = u_valid[i]; u_ls[i] = u_start[i]; u_lz[i] = u_size[i];
			u_lid[i] = u_id[i];
		end
		if (state_q == S_SHIFT) begin
			for (int i = 0; i < N; i++) begin
				if (ins && CW'(i) == idx_q && i > 0) begin
					f_ld[i] = 1'b1; f_lv[i] = f_valid[i-1];
					f_ls[i] = f_start[i-1]; f_lz[i] = f_size[i-1];
				end
				if (!ins && CW'(i) == idx_q && i < N-1) begin
					f_ld[i] = 1'b1; f_lv[i] = f_valid[i+1];
					f_ls[i] = f_start[i+1]; f_lz[i] = f_size[i+1];
				end
				if (!ins && CW'(i) == idx_q && i == N-1) begin
					f_ld[i] = 1'b1; f_lv[i] = 1'b0;
				end
			end
		end
		if (state_q == S_APPLY && hit_q) begin
			if (req_q.kind == vpa_pkg::KIND_ALLOC) begin
				u_ld[slot_q] = 1'b1; u_lv[slot_q] = 1'b1;
				u_ls[slot_q] = f_start[hit_idx_q]; u_lz[slot_q] = req_sz;
				u_lid[slot_q] = nid_q;
				if (!rem) begin
					f_ld[hit_idx_q] = 1'b1;
					f_ls[hit_idx_q] = new_start[AW-1:0];
					f_lz[hit_idx_q] = f_size[hit_idx_q] - req_sz;
				end
			end else begin
				u_ld[slot_q] = 1'b1; u_lv[slot_q] = 1'b0;
				if (left_q) begin
					f_ld[pm] = 1'b1;
					f_lz[pm] = f_size[pm] + u_size_q + (right_q ? f_size[pp] : '0);
				end else begin
					f_ld[pp] = 1'b1; f_lv[pp] = 1'b1; f_ls[pp] = u_start_q;
					f_lz[pp] = right_q ? (f_size[pp] + u_size_q) : u_size_q;
				end
			end
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q <= 1'b0;
			fcount_q <= SW'(1);
			nfp_q <= '0;
			nid_q <= '0;
			idx_q <= '0; cnt_q <= '0; pos_q <= '0;
			hit_q <= 1'b0; hit2_q <= 1'b0; slot_ok_q <= 1'b0;
			wrapped_q <= 1'b0;
		end else begin
			done_q <= (state_q == S_DONE);
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						req_q <= req;
						idx_q <= '0;
						hit_q <= 1'b0; hit2_q <= 1'b0; slot_ok_q <= 1'b0;
						pos_q <= CW'(fcount_q);
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					// Used row: free slot or id match; free row: fit.
					if (req_q.kind == vpa_pkg::KIND_ALLOC) begin
						if (!u_valid[ix] && !slot_ok_q) begin
							slot_ok_q <= 1'b1; slot_q <= ix;
						end
						if (SW'(idx_q) < fcount_q) begin
							if (fz_ix >= req_sz) begin
								unique case (req_q.fit_policy)
									vpa_pkg::FIT_FIRST, vpa_pkg::FIT_NEXT: begin
										if (!hit_q) begin
											hit_q <= 1'b1; hit_idx_q <= ix;
										end
										if (req_q.fit_policy == vpa_pkg::FIT_NEXT &&
										    !hit2_q && fend_ix > nfp_q) begin
											hit2_q <= 1'b1; first_q <= ix;
										end
									end
									vpa_pkg::FIT_BEST: begin
										if (!hit_q || fz_ix < best_size_q) begin
											hit_q <= 1'b1; hit_idx_q <= ix; best_size_q <= fz_ix;
										end
									end
									default: begin
										if (!hit_q || fz_ix > best_size_q) begin
											hit_q <= 1'b1; hit_idx_q <= ix; best_size_q <= fz_ix;
										end
									end
								endcase
							end
						end
					end else begin
						if (u_valid[ix] && u_id[ix] == req_q.free_id &&
						    (!hit_q || u_start[ix] < u_start_q)) begin
							hit_q <= 1'b1; slot_q <= ix;
							u_start_q <= u_start[ix]; u_size_q <= u_size[ix];
						end
					end
					if (idx_q == CW'(N - 1)) begin
						state_q <= S_PICK;
						idx_q <= '0;
					end else begin
						idx_q <= idx_q + CW'(1);
					end
				end
				S_PICK: begin
					if (req_q.kind == vpa_pkg::KIND_ALLOC) begin
						if (req_q.alloc_size == '0) begin
							rsp_q <= mk_rsp(vpa_pkg::ST_ZERO, '0, '0, '0);
							hit_q <= 1'b0;
							state_q <= S_DONE;
						end else if (!slot_ok_q) begin
							rsp_q <= mk_rsp(vpa_pkg::ST_FULL, '0, '0, '0);
							hit_q <= 1'b0;
							state_q <= S_DONE;
						end else if (!hit_q) begin
							rsp_q <= mk_rsp(vpa_pkg::ST_NO_SPACE, '0, '0, '0);
							state_q <= S_DONE;
						end else begin
							if (req_q.fit_policy == vpa_pkg::FIT_NEXT && hit2_q)
								hit_idx_q <= first_q;
							state_q <= S_APPLY;
						end
					end else if (idx_q == '0 && !hit_q) begin
						rsp_q <= mk_rsp(vpa_pkg::ST_NOT_FOUND, '0, '0, '0);
						state_q <= S_DONE;
					end else if (SW'(idx_q) < fcount_q &&
					             f_start[ix] < u_start_q) begin
						idx_q <= idx_q + CW'(1);
					end else begin
						pos_q <= idx_q;
						left_q <= (idx_q != '0) &&
							(pend == (AW+1)'(u_start_q));
						right_q <= (SW'(idx_q) < fcount_q) &&
							(nend == (AW+1)'(f_start[ix]));
						hit_q <= 1'b0;
						wrapped_q <= 1'b1;
						state_q <= S_APPLY;
					end
				end
				S_APPLY: begin
					// First visit with a release decides; shifts happen around it.
					if (req_q.kind == vpa_pkg::KIND_FREE && wrapped_q) begin
						wrapped_q <= 1'b0;
						if (ins && fcount_q >= SW'(N)) begin
							rsp_q <= mk_rsp(vpa_pkg::ST_FULL, '0, '0, '0);
							state_q <= S_DONE;
						end else if (ins) begin
							idx_q <= CW'(N - 1);
							state_q <= S_SHIFT;
						end else begin
							hit_q <= 1'b1;
						end
					end else begin
						if (req_q.kind == vpa_pkg::KIND_ALLOC) begin
							rsp_q <= mk_rsp(vpa_pkg::ST_OK, 14'(f_start[hit_idx_q]),
								15'(req_sz), nid_q);
							nid_q <= nid_q + 16'd1;
							if (req_q.fit_policy == vpa_pkg::FIT_NEXT)
								nfp_q <= (new_start >= (AW+1)'(POOL_SIZE)) ? '0 : new_start;
						end else begin
							rsp_q <= mk_rsp(vpa_pkg::ST_OK, 14'(u_start_q),
								15'(u_size_q), '0);
						end
						if (rem) begin
							idx_q <= (req_q.kind == vpa_pkg::KIND_FREE) ? pos_q
								: CW'(hit_idx_q);
							cnt_q <= '0;
							fcount_q <= fcount_q - SW'(1);
							state_q <= S_SHIFT;
						end else begin
							if (ins) fcount_q <= fcount_q + SW'(1);
							state_q <= S_DONE;
						end
					end
				end
				S_SHIFT: begin
					if (ins) begin
						if (idx_q == pos_q) begin
							hit_q <= 1'b1;
							state_q <= S_APPLY;
						end else begin
							idx_q <= idx_q - CW'(1);
						end
					end else if (idx_q == CW'(N - 1)) begin
						state_q <= S_DONE;
					end else begin
						idx_q <= idx_q + CW'(1);
					end
				end
				S_DONE: begin
					hit_q <= 1'b0;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	logic unused_ok;
	assign unused_ok = ^{f_id[0], cnt_q};
endmodule

/* src/vpa_checker.sv */
// ----------------------------------------------------------------------------
// vpa_checker
// Port-level checks of the request and result timing and of result values.
// ----------------------------------------------------------------------------
`include "variable_partition_allocator_unit_assert.svh"
module vpa_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input logic          done,
	input vpa_pkg::rsp_t rsp
);
	`VPA_ASSERT_NEXT(a_take_busy, start && !busy, busy, "request not taken")
	`VPA_ASSERT_NEXT(a_done_pulse, done, !done, "result strobe too long")
	`VPA_ASSERT_IMPL(a_status_range, done, rsp.status <= vpa_pkg::ST_ZERO, "bad status code")
	`VPA_ASSERT_IMPL(a_fail_zero, done && rsp.status != vpa_pkg::ST_OK, rsp.seg_size == '0 && rsp.assigned_id == '0, "failed result not zero")
endmodule

bind variable_partition_allocator_unit vpa_checker u_vpa_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done), .rsp(rsp)
);

/* tb/sv/variable_partition_allocator_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// variable_partition_allocator_unit_tb
// Self-checking bench for the pool allocator. A small scoreboard keeps its
// own copy of the free and used tables, predicts each request's result when
// the request is taken, and compares every strobed result in order. Directed
// requests cover the edges of the pool and the tables; random requests
// follow with idle gaps and a pause for the block to drain.
// ----------------------------------------------------------------------------
module variable_partition_allocator_unit_tb;
	localparam int unsigned POOL     = vpa_pkg::POOL_SIZE_DEF;
	localparam int unsigned SEGS     = vpa_pkg::MAX_SEGMENTS_DEF;
	localparam int unsigned N_RANDOM = 1230;
	localparam int unsigned WATCHDOG = 20000;
	localparam int unsigned TAIL     = 2 * SEGS + 20;

	class alloc_scoreboard;
		int unsigned   fr_start[SEGS];
		int unsigned   fr_size[SEGS];
		int unsigned   fr_count;
		bit            us_valid[SEGS];
		logic [15:0]   us_id[SEGS];
		int unsigned   us_start[SEGS];
		int unsigned   us_size[SEGS];
		int unsigned   nf_pos;
		logic [15:0]   next_id;
		vpa_pkg::rsp_t pending[$];
		int unsigned   mismatches;

		function new();
			foreach (us_valid[i]) us_valid[i] = 0;
			fr_start[0] = 0;
			fr_size[0]  = POOL;
			fr_count    = 1;
			nf_pos      = 0;
			next_id     = '0;
			mismatches  = 0;
		endfunction

		function void drop_free(int unsigned k);
			for (int unsigned i = k; i + 1 < fr_count; i++) begin
				fr_start[i] = fr_start[i + 1];
				fr_size[i]  = fr_size[i + 1];
			end
			fr_count--;
		endfunction

		function int choose_segment(vpa_pkg::fit_t pol, int unsigned sz);
			int pick;
			int unsigned first, j;
			pick = -1;
			case (pol)
				vpa_pkg::FIT_FIRST: begin
					for (int unsigned i = 0; i < fr_count; i++)
						if (fr_size[i] >= sz) return i;
				end
				vpa_pkg::FIT_NEXT: begin
					first = fr_count;
					for (int unsigned i = 0; i < fr_count; i++)
						if (fr_start[i] + fr_size[i] > nf_pos) begin
							first = i;
							break;
						end
					for (int unsigned n = 0; n < fr_count; n++) begin
						j = first + n;
						if (j >= fr_count) j -= fr_count;
						if (fr_size[j] >= sz) return j;
					end
				end
				default: begin
					for (int unsigned i = 0; i < fr_count; i++) begin
						if (fr_size[i] < sz) continue;
						if (pick < 0 ||
						    (pol == vpa_pkg::FIT_BEST && fr_size[i] < fr_size[pick]) ||
						    (pol == vpa_pkg::FIT_WORST && fr_size[i] > fr_size[pick]))
							pick = i;
					end
				end
			endcase
			return pick;
		endfunction

		function void note_request(vpa_pkg::req_t r);
			vpa_pkg::rsp_t e;
			int slot, k, hit;
			int unsigned sz, s, z, pos;
			bit left, right;
			e = '0;
			e.status = vpa_pkg::ST_OK;
			if (r.kind == vpa_pkg::KIND_ALLOC) begin
				sz = r.alloc_size;
				slot = -1;
				for (int i = 0; i < SEGS; i++)
					if (!us_valid[i]) begin
						slot = i;
						break;
					end
				k = -1;
				if (sz != 0 && slot >= 0)
					k = choose_segment(vpa_pkg::fit_t'(r.fit_policy), sz);
				if (sz == 0) e.status = vpa_pkg::ST_ZERO;
				else if (slot < 0) e.status = vpa_pkg::ST_FULL;
				else if (k < 0) e.status = vpa_pkg::ST_NO_SPACE;
				else begin
					e.seg_start   = fr_start[k][13:0];
					e.seg_size    = sz[14:0];
					e.assigned_id = next_id;
					us_valid[slot] = 1;
					us_id[slot]    = next_id;
					us_start[slot] = fr_start[k];
					us_size[slot]  = sz;
					next_id++;
					fr_start[k] += sz;
					fr_size[k]  -= sz;
					if (vpa_pkg::fit_t'(r.fit_policy) == vpa_pkg::FIT_NEXT)
						nf_pos = (fr_start[k] >= POOL) ? 0 : fr_start[k];
					if (fr_size[k] == 0) drop_free(k);
				end
			end else begin
				hit = -1;
				for (int i = 0; i < SEGS; i++)
					if (us_valid[i] && us_id[i] == r.free_id &&
					    (hit < 0 || us_start[i] < us_start[hit]))
						hit = i;
				if (hit < 0) e.status = vpa_pkg::ST_NOT_FOUND;
				else begin
					s = us_start[hit];
					z = us_size[hit];
					pos = 0;
					while (pos < fr_count && fr_start[pos] < s) pos++;
					left  = pos > 0 && fr_start[pos - 1] + fr_size[pos - 1] == s;
					right = pos < fr_count && s + z == fr_start[pos];
					if (!left && !right && fr_count >= SEGS) e.status = vpa_pkg::ST_FULL;
					else begin
						us_valid[hit] = 0;
						e.seg_start = s[13:0];
						e.seg_size  = z[14:0];
						if (left && right) begin
							fr_size[pos - 1] += z + fr_size[pos];
							drop_free(pos);
						end else if (left) begin
							fr_size[pos - 1] += z;
						end else if (right) begin
							fr_start[pos] = s;
							fr_size[pos] += z;
						end else begin
							for (int unsigned i = fr_count; i > pos; i--) begin
								fr_start[i] = fr_start[i - 1];
								fr_size[i]  = fr_size[i - 1];
							end
							fr_start[pos] = s;
							fr_size[pos]  = z;
							fr_count++;
						end
					end
				end
			end
			pending.push_back(e);
		endfunction

		function void check_response(vpa_pkg::rsp_t a);
			vpa_pkg::rsp_t e;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h", a);
				return;
			end
			e = pending.pop_front();
			if (a !== e) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"mismatch: expected st=%0d start=%0d size=%0d id=%0d,",
					          " got st=%0d start=%0d size=%0d id=%0d"},
					         e.status, e.seg_start, e.seg_size, e.assigned_id,
					         a.status, a.seg_start, a.seg_size, a.assigned_id);
			end
		endfunction

		// Returns a live identifier, or a random one when nothing is held.
		function logic [15:0] live_id();
			int idx[$];
			for (int i = 0; i < SEGS; i++) if (us_valid[i]) idx.push_back(i);
			if (idx.size() == 0) return $urandom;
			return us_id[idx[$urandom_range(0, idx.size() - 1)]];
		endfunction
	endclass

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          start = 1'b0;
	vpa_pkg::req_t req = '0;
	logic          busy, done;
	vpa_pkg::rsp_t rsp;

	alloc_scoreboard sb;
	int unsigned idle_cycles = 0;
	bit          allow_idle = 1;

	variable_partition_allocator_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .req(req),
		.busy(busy), .done(done), .rsp(rsp)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				sb.note_request(req);
				idle_cycles <= 0;
			end else if (done) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
			if (done) sb.check_response(rsp);
			if (idle_cycles >= WATCHDOG) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	function automatic vpa_pkg::req_t alloc_req(vpa_pkg::fit_t pol, int unsigned sz);
		vpa_pkg::req_t r;
		r.kind       = vpa_pkg::KIND_ALLOC;
		r.fit_policy = pol;
		r.alloc_size = sz[14:0];
		r.free_id    = $urandom;
		return r;
	endfunction

	function automatic vpa_pkg::req_t free_req(logic [15:0] id);
		vpa_pkg::req_t r;
		r.kind       = vpa_pkg::KIND_FREE;
		r.fit_policy = $urandom;
		r.alloc_size = $urandom;
		r.free_id    = id;
		return r;
	endfunction

	task automatic send(vpa_pkg::req_t r);
		start <= 1'b1;
		req   <= r;
		do @(posedge clk); while (busy);
		@(negedge clk);
		if (allow_idle && $urandom_range(0, 99) < 28) begin
			start <= 1'b0;
			req   <= $urandom;
			repeat ($urandom_range(1, 40)) @(negedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (TAIL) @(negedge clk);
	endtask

	function automatic int unsigned random_size();
		int unsigned p;
		p = $urandom_range(0, 99);
		if (p < 70) return $urandom_range(1, 1024);
		if (p < 85) return $urandom_range(1, 8192);
		if (p < 90) return POOL;
		if (p < 95) return 0;
		return $urandom_range(0, 32767);
	endfunction

	initial begin
		sb = new();
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part: pool edges, zero size, unknown id, table full.
		send(alloc_req(vpa_pkg::FIT_FIRST, 0));
		send(alloc_req(vpa_pkg::FIT_FIRST, POOL));
		send(alloc_req(vpa_pkg::FIT_BEST, 1));
		send(free_req(16'd0));
		send(free_req(16'd0));
		send(alloc_req(vpa_pkg::FIT_WORST, 32767));
		send(free_req(16'hFFFF));
		for (int i = 0; i < 16; i++)
			send(alloc_req(vpa_pkg::fit_t'(i % 4), 100 + 37 * i));
		send(alloc_req(vpa_pkg::FIT_NEXT, 5));
		send(alloc_req(vpa_pkg::FIT_FIRST, 0));
		for (int i = 1; i < 17; i += 2) send(free_req(i[15:0]));
		send(free_req(16'd4));
		send(free_req(16'd2));
		send(alloc_req(vpa_pkg::FIT_BEST, 100));
		send(alloc_req(vpa_pkg::FIT_WORST, 150));
		send(alloc_req(vpa_pkg::FIT_NEXT, 120));
		drain();

		for (int n = 0; n < N_RANDOM; n++) begin
			allow_idle = !(n >= 400 && n < 600);
			if (n == 800) drain();
			case ($urandom_range(0, 99)) inside
				[0:54]:  send(alloc_req(vpa_pkg::fit_t'($urandom_range(0, 3)), random_size()));
				[55:94]: send(free_req(sb.live_id()));
				default: send(free_req($urandom));
			endcase
		end

		drain();
		if (sb.mismatches == 0 && sb.pending.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end
endmodule
